### rtl/core/ima_pkg.sv
// Shared types, constants and table functions for the ADPCM encoder.
`default_nettype none
package ima_pkg;

    localparam int unsigned SampleW   = 16;
    localparam int unsigned CodeW     = 4;
    localparam int unsigned StepPosW  = 7;
    localparam int unsigned StepW     = 15;
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = 2;
    localparam int unsigned QueueCntW  = 3;
    localparam logic [StepPosW-1:0] MaxStepPos = 7'd88;
    localparam logic [3:0] LowNibbleMask  = 4'hf;

    // One encoded code on its way from the encoder to the packer.
    typedef struct packed {
        logic [CodeW-1:0] code;
        logic             block_end;
    } t_code_req;

    // Standard 89-entry step size table.
    function automatic logic [StepW-1:0] step_size(input logic [StepPosW-1:0] pos);
        logic [StepW-1:0] s;
        begin
            unique case (pos)
                7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
                7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
                7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
                7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
                7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
                7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
                7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
                7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
                7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
                7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
                7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
                7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
                7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
                7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
                7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
                7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
                7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
                7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
                7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
                7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
                7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
                7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
                7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
                7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
                7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
                7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
                7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
                7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
                7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
                7'd87: s = 15'd29794;
                default: s = 15'd32767;
            endcase
            return s;
        end
    endfunction

    // Index adjust: -1 for magnitudes 0..3, then 2, 4, 6, 8.
    function automatic logic signed [4:0] idx_adjust(input logic [2:0] mag);
        logic signed [4:0] a;
        begin
            unique case (mag)
                3'd4:    a = 5'sd2;
                3'd5:    a = 5'sd4;
                3'd6:    a = 5'sd6;
                3'd7:    a = 5'sd8;
                default: a = -5'sd1;
            endcase
            return a;
        end
    endfunction

endpackage
`default_nettype wire

### rtl/core/ima_front.sv
// Front end: takes samples and runs the predictor / step index recurrence.
`default_nettype none
module ima_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic signed [ima_pkg::SampleW-1:0] i_sample,
    input  wire logic                           i_block_end,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_q_full,
    output logic                                o_push,
    output ima_pkg::t_code_req                  o_push_req
);
    import ima_pkg::*;

    logic signed [SampleW-1:0]  r_pred;
    logic signed [SampleW-1:0]  n_pred;
    logic [StepPosW-1:0]        r_step_pos;
    logic [StepPosW-1:0]        n_step_pos;

    logic [StepPosW-1:0]        pos;
    logic [StepW-1:0]           step;
    logic [StepW-1:0]           step_h;
    logic [StepW-1:0]           step_q;
    logic signed [SampleW:0]    diff;
    logic                       neg;
    logic [SampleW:0]           mag;
    logic [SampleW:0]           recon;
    logic [2:0]                 mbits;
    logic signed [SampleW+1:0]  next;
    logic signed [4:0]          adj;
    logic signed [StepPosW:0]   p;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        pos    = (r_step_pos > MaxStepPos) ? MaxStepPos : r_step_pos;
        step   = step_size(pos);
        step_h = step >> 1;
        step_q = step >> 2;
        diff   = {i_sample[SampleW-1], i_sample} - {r_pred[SampleW-1], r_pred};
        neg    = diff[SampleW];
        mag    = neg ? ((SampleW+1)'(0) - diff) : diff;
        recon  = {2'b00, step >> 3};
        mbits  = 3'b000;
        if (mag >= {2'b00, step}) begin
            mbits[2] = 1'b1;
            mag      = mag - {2'b00, step};
            recon    = recon + {2'b00, step};
        end
        if (mag >= {2'b00, step_h}) begin
            mbits[1] = 1'b1;
            mag      = mag - {2'b00, step_h};
            recon    = recon + {2'b00, step_h};
        end
        if (mag >= {2'b00, step_q}) begin
            mbits[0] = 1'b1;
            recon    = recon + {2'b00, step_q};
        end

        // predictor update, saturated to 16 bits
        if (neg) begin
            next = {{2{r_pred[SampleW-1]}}, r_pred} - $signed({1'b0, recon});
        end else begin
            next = {{2{r_pred[SampleW-1]}}, r_pred} + $signed({1'b0, recon});
        end
        if (next > 18'sd32767) begin
            n_pred = 16'sh7fff;
        end else if (next < -18'sd32768) begin
            n_pred = 16'sh8000;
        end else begin
            n_pred = next[SampleW-1:0];
        end

        // step index update, clamped to 0..88
        adj = idx_adjust(mbits);
        p   = $signed({1'b0, pos}) + $signed({{(StepPosW-4){adj[4]}}, adj});
        if (p < 0) begin
            n_step_pos = '0;
        end else if (p > $signed({1'b0, MaxStepPos})) begin
            n_step_pos = MaxStepPos;
        end else begin
            n_step_pos = p[StepPosW-1:0];
        end

        o_push_req.code      = {neg, mbits};
        o_push_req.block_end = i_block_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred     <= '0;
            r_step_pos <= '0;
        end else if (o_push) begin
            r_pred     <= n_pred;
            r_step_pos <= n_step_pos;
        end
    end

endmodule
`default_nettype wire

### rtl/core/ima_queue.sv
// Short code queue between encoder and packer.
`default_nettype none
module ima_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  ima_pkg::t_code_req      i_push_req,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic                    o_avail,
    output ima_pkg::t_code_req      o_head
);
    import ima_pkg::*;

    t_code_req              r_mem [QueueDepth];
    logic [QueuePtrW-1:0]   r_wr_ptr;
    logic [QueuePtrW-1:0]   r_rd_ptr;
    logic [QueueCntW-1:0]   r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_count == QueueCntW'(QueueDepth));
    assign o_avail = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/core/ima_back.sv
// Back end: pairs codes into bytes and holds the output register.
`default_nettype none
module ima_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_avail,
    input  ima_pkg::t_code_req      i_head,
    output logic                    o_pop,
    output logic [7:0]              o_packed_byte,
    output logic                    o_last_of_block,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready
);
    import ima_pkg::*;

    logic [CodeW-1:0]   r_held;
    logic               r_pending;
    logic [7:0]         r_byte;
    logic               r_last;
    logic               r_valid;
    logic               out_free;
    logic               emit;

    assign out_free        = !r_valid || i_out_ready;
    assign o_pop           = i_avail && out_free;
    assign emit            = o_pop && (r_pending || i_head.block_end);
    assign o_packed_byte   = r_byte;
    assign o_last_of_block = r_last;
    assign o_out_valid     = r_valid;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (r_pending) begin
                r_byte <= {i_head.code, r_held & LowNibbleMask};
                r_last <= i_head.block_end;
            end else begin
                r_byte <= {4'h0, i_head.code};
                r_last <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_pending <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                if (r_pending || i_head.block_end) begin
                    r_held    <= '0;
                    r_pending <= 1'b0;
                end else begin
                    r_held    <= i_head.code;
                    r_pending <= 1'b1;
                end
            end
            if (emit) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/ima_adpcm_encoder.sv
// IMA/DVI 4-bit ADPCM encoder top level: encoder front, code queue, byte packer.
//
// Input channel (i_in_valid / o_in_ready): one request carries a signed 16-bit
// PCM sample and a block-end flag. Output channel (o_out_valid / i_out_ready):
// one request carries a packed byte (earlier code in the low nibble) and a
// last-of-block flag. Two samples give one byte; a block end on an odd sample
// gives a byte with that code alone and a zero high nibble.
// The front encodes one sample per cycle while the queue is not full: predictor
// and step index are computed combinationally and registered with each accepted
// sample. Codes pass through a 4-entry queue to the packer, which drives a
// registered output. The code of the sample that completes a byte is written
// into the queue and, once at its head, packed into the output register.
// A receiver stall fills the output register, then the queue; o_in_ready drops
// only when the queue holds 4 codes, so the input keeps flowing until then.
// Reset (synchronous, active low) clears predictor, step index, the pending
// nibble, the queue and the output valid.
`default_nettype none
module ima_adpcm_encoder (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic signed [15:0]     i_sample,
    input  wire logic                   i_block_end,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    output logic [7:0]                  o_packed_byte,
    output logic                        o_last_of_block,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready
);
    import ima_pkg::*;

    t_code_req  push_req;
    t_code_req  head;
    logic       push;
    logic       q_full;
    logic       q_avail;
    logic       pop;

    ima_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (i_sample),
        .i_block_end (i_block_end),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_req  (push_req)
    );

    ima_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_req (push_req),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_avail    (q_avail),
        .o_head     (head)
    );

    ima_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_avail         (q_avail),
        .i_head          (head),
        .o_pop           (pop),
        .o_packed_byte   (o_packed_byte),
        .o_last_of_block (o_last_of_block),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready)
    );

endmodule
`default_nettype wire
